// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Request and result types, status codes, modes and controller states.
// ----------------------------------------------------------------------------
package rau_pkg;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] left_num;
		logic signed [31:0] left_den;
		logic signed [31:0] right_num;
		logic signed [31:0] right_den;
	} request_t;

	typedef struct packed {
		logic signed [31:0] result_num;
		logic [30:0]        result_den;
		logic [1:0]         status;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_RED_L,
		S_RED_R,
		S_CHECK,
		S_MUL1,
		S_MUL2,
		S_COMBINE,
		S_RED_O,
		S_FINISH,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_LOAD,
		DP_MUL1,
		DP_MUL2,
		DP_COMBINE,
		DP_FINISH
	} dp_op_t;

	// Reduction unit selection
	typedef enum logic [1:0] {
		RED_L,
		RED_R,
		RED_O
	} red_sel_t;

	typedef struct packed {
		dp_op_t   op;
		logic     red_start;
		red_sel_t red_sel;
		logic     red_store;
	} dp_cmd_t;

	typedef struct packed {
		logic    red_busy;
		logic    red_done;
		status_t early_status;
	} dp_stat_t;

endpackage

// ----- rtl/rau_reducer.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit fraction reducer
// Euclidean gcd by restoring division one quotient bit a cycle, then two
// restoring divisions of numerator and denominator by the gcd.
// ----------------------------------------------------------------------------
module rau_reducer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic        done,
	output logic [63:0] num_out,
	output logic [63:0] den_out
);
	import rau_pkg::*;

	typedef enum logic [2:0] {
		R_IDLE, R_GCD, R_DIVN, R_DIVD, R_DONE
	} rstate_t;

	rstate_t     state_q;
	logic [63:0] a_q, b_q, n0_q, d0_q;
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [5:0]  bit_q;
	logic        mod_active_q;
	logic [64:0] trial;
	logic [63:0] rem_next, quo_next;

	assign trial    = {rem_q, quo_q[63]} - {1'b0, dvs_q};
	assign rem_next = trial[64] ? {rem_q[62:0], quo_q[63]} : trial[63:0];
	assign quo_next = {quo_q[62:0], ~trial[64]};

	assign busy = (state_q != R_IDLE) && (state_q != R_DONE);
	assign done = (state_q == R_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= R_IDLE;
			bit_q        <= '0;
			mod_active_q <= 1'b0;
		end else begin
			case (state_q)
				R_IDLE, R_DONE: begin
					if (start) begin
						if (num == 64'd0) begin
							num_out <= 64'd0;
							den_out <= 64'd1;
							state_q <= R_DONE;
						end else begin
							a_q          <= num;
							b_q          <= den;
							n0_q         <= num;
							d0_q         <= den;
							mod_active_q <= 1'b0;
							state_q      <= R_GCD;
						end
					end else if (state_q == R_DONE) begin
						state_q <= R_IDLE;
					end
				end
				R_GCD: begin
					if (!mod_active_q) begin
						if (a_q == 64'd0 || b_q == 64'd0) begin
							dvs_q   <= a_q | b_q;
							quo_q   <= n0_q;
							rem_q   <= '0;
							bit_q   <= '0;
							state_q <= R_DIVN;
						end else begin
							quo_q        <= (a_q > b_q) ? a_q : b_q;
							dvs_q        <= (a_q > b_q) ? b_q : a_q;
							rem_q        <= '0;
							bit_q        <= '0;
							mod_active_q <= 1'b1;
						end
					end else begin
						rem_q <= rem_next;
						quo_q <= quo_next;
						bit_q <= bit_q + 6'd1;
						if (bit_q == 6'd63) begin
							mod_active_q <= 1'b0;
							if (a_q > b_q) a_q <= rem_next;
							else           b_q <= rem_next;
						end
					end
				end
				R_DIVN: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd63) begin
						num_out <= quo_next;
						quo_q   <= d0_q;
						rem_q   <= '0;
						state_q <= R_DIVD;
					end
				end
				R_DIVD: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd63) begin
						den_out <= quo_next;
						state_q <= R_DONE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, sign and magnitude split, cross products and the
// reducer, all steered by the controller's commands.
// ----------------------------------------------------------------------------
module rau_datapath #(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rau_pkg::request_t req,
	input  rau_pkg::dp_cmd_t  cmd,
	output rau_pkg::dp_stat_t stat,
	output rau_pkg::result_t  res
);
	import rau_pkg::*;

	localparam int EW = (WIDTH > 32) ? 32 : WIDTH;
	localparam logic [63:0] LIM = (64'd1 << (EW - 1)) - 64'd1;

	logic [1:0]  mode_q;
	logic        ls_q, rs_q, sgn_q;
	logic [63:0] ln_q, ld_q, rn_q, rd_q;
	logic [63:0] p_q, q_q, num_q, den_q;
	logic [63:0] red_num, red_den, red_nout, red_dout;
	logic        red_busy, red_done;
	result_t     res_q;
	logic        qs;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	always_comb begin
		case (cmd.red_sel)
			RED_L:   begin red_num = ln_q;  red_den = ld_q;  end
			RED_R:   begin red_num = rn_q;  red_den = rd_q;  end
			default: begin red_num = num_q; red_den = den_q; end
		endcase
	end

	rau_reducer u_red (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.red_start),
		.num     (red_num),
		.den     (red_den),
		.busy    (red_busy),
		.done    (red_done),
		.num_out (red_nout),
		.den_out (red_dout)
	);

	always_comb begin
		qs = (mode_q == MODE_SUB) ? !rs_q : rs_q;
		if (p_q == 64'd0 && q_q == 64'd0) qs = 1'b0;
	end

	always_comb begin
		stat.red_busy = red_busy;
		stat.red_done = red_done;
		if (ld_q == 64'd0 || rd_q == 64'd0)
			stat.early_status = ST_ZERO_DEN;
		else if (mode_q == MODE_DIV && rn_q == 64'd0)
			stat.early_status = ST_DIV_ZERO;
		else
			stat.early_status = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (cmd.red_store && red_done) begin
			case (cmd.red_sel)
				RED_L: begin
					ln_q <= red_nout; ld_q <= red_dout;
					if (red_nout == 64'd0) ls_q <= 1'b0;
				end
				RED_R: begin
					rn_q <= red_nout; rd_q <= red_dout;
					if (red_nout == 64'd0) rs_q <= 1'b0;
				end
				default: begin
					num_q <= red_nout; den_q <= red_dout;
					if (red_nout == 64'd0) sgn_q <= 1'b0;
				end
			endcase
		end
		case (cmd.op)
			DP_LOAD: begin
				mode_q <= req.mode;
				ln_q   <= {32'd0, mag32(req.left_num)};
				ld_q   <= {32'd0, mag32(req.left_den)};
				rn_q   <= {32'd0, mag32(req.right_num)};
				rd_q   <= {32'd0, mag32(req.right_den)};
				ls_q   <= req.left_num[31] ^ req.left_den[31];
				rs_q   <= req.right_num[31] ^ req.right_den[31];
			end
			DP_MUL1: begin
				p_q <= ln_q[31:0] * ((mode_q == MODE_MUL) ? rn_q[31:0] : rd_q[31:0]);
				q_q <= (mode_q == MODE_MUL) ? 64'd0 : ld_q[31:0] * rn_q[31:0];
			end
			DP_MUL2: begin
				den_q <= ((mode_q == MODE_DIV) ? rn_q[31:0] : rd_q[31:0]) *
					((mode_q == MODE_DIV) ? ld_q[31:0] : ld_q[31:0]);
				if (mode_q == MODE_MUL || mode_q == MODE_DIV) begin
					num_q <= p_q;
					sgn_q <= ls_q ^ rs_q;
				end
			end
			DP_COMBINE: begin
				if (mode_q == MODE_ADD || mode_q == MODE_SUB) begin
					if (ls_q == qs) begin
						num_q <= p_q + q_q; sgn_q <= ls_q;
					end else if (p_q >= q_q) begin
						num_q <= p_q - q_q; sgn_q <= ls_q;
					end else begin
						num_q <= q_q - p_q; sgn_q <= qs;
					end
				end
			end
			DP_FINISH: begin
				if (stat.early_status != ST_OK) begin
					res_q.result_num <= '0;
					res_q.result_den <= '0;
					res_q.status     <= stat.early_status;
				end else if (num_q > LIM || den_q > LIM) begin
					res_q.result_num <= '0;
					res_q.result_den <= '0;
					res_q.status     <= ST_OVERFLOW;
				end else begin
					res_q.result_num <= sgn_q ? (32'd0 - num_q[31:0]) : num_q[31:0];
					res_q.result_den <= den_q[30:0];
					res_q.status     <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;

endmodule

// ----- rtl/rau_control.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences loading, operand reduction, products, result reduction and
// the output handshake.
// ----------------------------------------------------------------------------
module rau_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  rau_pkg::dp_stat_t stat,
	output rau_pkg::dp_cmd_t  cmd
);
	import rau_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_LOAD;
			S_LOAD:    state_d = (stat.early_status == ST_ZERO_DEN) ? S_FINISH : S_RED_L;
			S_RED_L:   if (stat.red_done) state_d = S_RED_R;
			S_RED_R:   if (stat.red_done) state_d = S_CHECK;
			S_CHECK:   state_d = (stat.early_status != ST_OK) ? S_FINISH : S_MUL1;
			S_MUL1:    state_d = S_MUL2;
			S_MUL2:    state_d = S_COMBINE;
			S_COMBINE: state_d = S_RED_O;
			S_RED_O:   if (stat.red_done) state_d = S_FINISH;
			S_FINISH:  state_d = S_OUT;
			S_OUT:     if (!out_stall) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '{op: DP_NONE, red_start: 1'b0, red_sel: RED_L, red_store: 1'b0};
		in_stall  = (state_q != S_IDLE);
		out_valid = (state_q == S_OUT);
		case (state_q)
			S_IDLE: if (in_valid) cmd.op = DP_LOAD;
			S_LOAD: begin
				cmd.red_sel   = RED_L;
				cmd.red_start = (stat.early_status != ST_ZERO_DEN);
			end
			S_RED_L: begin
				cmd.red_sel   = RED_L;
				cmd.red_store = 1'b1;
			end
			S_RED_R: begin
				cmd.red_sel   = RED_R;
				cmd.red_store = stat.red_done;
				cmd.red_start = !stat.red_busy && !stat.red_done;
			end
			S_MUL1:    cmd.op = DP_MUL1;
			S_MUL2:    cmd.op = DP_MUL2;
			S_COMBINE: begin
				cmd.op        = DP_COMBINE;
			end
			S_RED_O: begin
				cmd.red_sel   = RED_O;
				cmd.red_store = 1'b1;
				cmd.red_start = !stat.red_busy && !stat.red_done;
			end
			S_FINISH: cmd.op = DP_FINISH;
			default: ;
		endcase
	end

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// One request takes two fractions and a mode, one result comes back reduced.
// A request is taken only while the unit is idle and occupies it until its
// result is taken. The shared gcd reducer works one quotient bit per cycle.
// A zero denominator is reported without any reduction. Otherwise up to
// three reductions run one after another: a zero numerator gives 0/1
// directly, and a nonzero value runs Euclidean steps and then two final
// divisions. The time a request takes depends on the operands.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rau_pkg::request_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rau_pkg::result_t  out_data
);
	import rau_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rau_control u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rau_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (in_data),
		.cmd    (cmd),
		.stat   (stat),
		.res    (out_data)
	);

endmodule

// ----- rtl/rau_checker.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit port checker
// Watches the ports for result handshake and content rules.
// ----------------------------------------------------------------------------
module rau_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input rau_pkg::result_t out_data
);
	import rau_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result offered straight after a request");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
		out_data.result_num == '0 && out_data.result_den == '0)
		else $error("error result not zero");

	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OK |-> out_data.result_den != '0)
		else $error("zero denominator on good result");

endmodule

bind rational_arithmetic_unit rau_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends fraction requests in bursts against a stalling receiver. Each result
// is checked against a locally computed reduced fraction and status code.
// ----------------------------------------------------------------------------
module testbench;
	import rau_pkg::*;

	localparam int WDOG_LIMIT = 200000;
	localparam longint unsigned FIT_LIMIT = 64'h7FFF_FFFF;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	request_t in_data;
	logic     out_valid;
	logic     out_stall;
	result_t  out_data;

	result_t  expected_results[$];
	int       mismatches;
	int       idle_cycles;
	int       burst_left;
	int       stall_style;
	int       stall_phase;

	rational_arithmetic_unit #(.WIDTH(32)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic void to_sign_mag(input logic [31:0] v, output bit neg,
			output longint unsigned mag);
		neg = v[31];
		mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
	endfunction

	function automatic longint unsigned gcd64(input longint unsigned a,
			input longint unsigned b);
		while (a != 0 && b != 0) begin
			if (a > b)
				a = a % b;
			else
				b = b % a;
		end
		return a + b;
	endfunction

	function automatic void reduce_fraction(inout bit neg, inout longint unsigned n,
			inout longint unsigned d);
		longint unsigned g;
		if (n == 0) begin
			neg = 1'b0;
			d = 1;
		end else begin
			g = gcd64(n, d);
			n = n / g;
			d = d / g;
		end
	endfunction

	function automatic result_t predict_fraction(input request_t r);
		result_t res;
		bit ls, lds, rs, rds, qs, sgn;
		longint unsigned ln, ld, rn, rd, p, q, num, den;
		res = '0;
		res.status = ST_OK;
		to_sign_mag(r.left_num, ls, ln);
		to_sign_mag(r.left_den, lds, ld);
		to_sign_mag(r.right_num, rs, rn);
		to_sign_mag(r.right_den, rds, rd);
		if (ld == 0 || rd == 0) begin
			res.status = ST_ZERO_DEN;
			return res;
		end
		ls = ls ^ lds;
		rs = rs ^ rds;
		reduce_fraction(ls, ln, ld);
		reduce_fraction(rs, rn, rd);
		if (r.mode == MODE_DIV && rn == 0) begin
			res.status = ST_DIV_ZERO;
			return res;
		end
		case (r.mode)
			MODE_ADD, MODE_SUB: begin
				p = ln * rd;
				q = ld * rn;
				qs = (r.mode == MODE_SUB) ? !rs : rs;
				if (p == 0)
					qs = (q == 0) ? 1'b0 : qs;
				if (ls == qs) begin
					num = p + q;
					sgn = ls;
				end else if (p >= q) begin
					num = p - q;
					sgn = ls;
				end else begin
					num = q - p;
					sgn = qs;
				end
				den = ld * rd;
			end
			MODE_MUL: begin
				num = ln * rn;
				den = ld * rd;
				sgn = ls ^ rs;
			end
			default: begin
				num = ln * rd;
				den = ld * rn;
				sgn = ls ^ rs;
			end
		endcase
		reduce_fraction(sgn, num, den);
		if (num > FIT_LIMIT || den > FIT_LIMIT) begin
			res.status = ST_OVERFLOW;
			return res;
		end
		res.result_num = sgn ? (32'd0 - num[31:0]) : num[31:0];
		res.result_den = den[30:0];
		return res;
	endfunction

	function automatic logic [31:0] pick_value(input int kind);
		int v;
		case (kind)
			0: begin
				v = $urandom_range(40);
				v = v - 20;
			end
			1: begin
				v = $urandom_range(65535);
				v = v - 32768;
			end
			2: v = $urandom;
			default: begin
				case ($urandom_range(5))
					0: v = 0;
					1: v = 1;
					2: v = -1;
					3: v = 32'h7FFF_FFFF;
					4: v = 32'h8000_0000;
					default: v = 32'h8000_0001;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic request_t make_request(input mode_t m, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		request_t r;
		r.mode = m;
		r.left_num = a;
		r.left_den = b;
		r.right_num = c;
		r.right_den = d;
		return r;
	endfunction

	task automatic send_request(input request_t r);
		in_valid <= 1'b1;
		in_data <= r;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(predict_fraction(r));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(12);
			if ($urandom_range(3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_extremes();
		mode_t m;
		for (int i = 0; i < 4; i++) begin
			m = mode_t'(i);
			send_request(make_request(m, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1));
			send_request(make_request(m, 32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF));
			send_request(make_request(m, 6, -4, -9, 12));
		end
		send_request(make_request(MODE_ADD, 32'h8000_0000, 1, 0, 5));
		send_request(make_request(MODE_SUB, 3, 7, 3, 7));
		send_request(make_request(MODE_MUL, 32'h8000_0000, 3, 3, 32'h8000_0000));
		send_request(make_request(MODE_DIV, 0, -7, 5, 2));
	endtask

	task automatic test_errors();
		send_request(make_request(MODE_ADD, 1, 0, 1, 1));
		send_request(make_request(MODE_DIV, 1, 0, 0, 0));
		send_request(make_request(MODE_MUL, 1, 1, 1, 0));
		send_request(make_request(MODE_DIV, 4, 3, 0, -5));
		send_request(make_request(MODE_DIV, 1, 1, 0, 32'h8000_0000));
		send_request(make_request(MODE_MUL, 32'h7FFF_FFFF, 2, 32'h7FFF_FFFF, 3));
		send_request(make_request(MODE_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE));
	endtask

	task automatic test_random(input int count, input int max_kind);
		for (int i = 0; i < count; i++)
			send_request(make_request(mode_t'($urandom_range(3)),
				pick_value($urandom_range(max_kind)), pick_value($urandom_range(max_kind)),
				pick_value($urandom_range(max_kind)), pick_value($urandom_range(max_kind))));
	endtask

	task automatic test_pause_until_drained();
		wait_for_drain();
		stall_style = 0;
		test_random(20, 1);
		wait_for_drain();
		stall_style = 3;
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result num=%0d den=%0d status=%0d",
						out_data.result_num, out_data.result_den, out_data.status);
				mismatches++;
			end else begin
				if (out_data !== expected_results[0]) begin
					if (mismatches < 10)
						$display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
							expected_results[0].result_num, expected_results[0].result_den,
							expected_results[0].status, out_data.result_num,
							out_data.result_den, out_data.status);
					mismatches++;
				end
				void'(expected_results.pop_front());
			end
		end
		stall_phase++;
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(3) == 0);
			2: out_stall <= (stall_phase % 23) < 9;
			default: out_stall <= ($urandom_range(1) == 0);
		endcase
		if ($urandom_range(499) == 0)
			stall_style = $urandom_range(3);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("rational_arithmetic_unit regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 0;
		stall_style = 1;
		stall_phase = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_errors();
		test_pause_until_drained();
		test_random(900, 1);
		test_random(400, 3);
		wait_for_drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("rational_arithmetic_unit regression: pass");
		else
			$display("rational_arithmetic_unit regression: fail");
		$finish;
	end
endmodule
